// ===== rtl/core/tsctd_pkg.sv =====
// Package for the tick-counter timebase discipline core.
// Holds item kind codes, register indexes, constants and saturating helpers.
// No dependencies.
`timescale 1ns / 1ps

package tsctd_pkg;

   typedef enum logic [2:0] {
      KIND_INIT    = 3'd0,
      KIND_RESYNC  = 3'd1,
      KIND_TICKS   = 3'd2,
      KIND_NOW     = 3'd3,
      KIND_TO_TICK = 3'd4
   } kind_type;

   // Configuration register indexes
   localparam logic CSR_ERROR_NS   = 1'b0;
   localparam logic CSR_INITIAL_HZ = 1'b1;

   localparam logic [63:0] NS_PER_S  = 64'd1000000000;
   localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   // Largest value whose product with NS_PER_S fits in 64 bits
   localparam logic [63:0] SEC_LIMIT = ALL_ONES / NS_PER_S;

   localparam logic [29:0] ERROR_NS_RESET   = 30'd1000000;
   localparam logic [33:0] INITIAL_HZ_RESET = 34'd1000000000;

   // Saturating add: {saturated, sum}
   function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s[64]) return {1'b1, ALL_ONES};
      return {1'b0, s[63:0]};
   endfunction

   // Saturating subtract: {saturated, difference}
   function automatic logic [64:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
      if (b > a) return {1'b1, 64'd0};
      return {1'b0, a - b};
   endfunction

endpackage

// ===== rtl/core/tsc_timebase_discipline_core.sv =====
// Top level of the tick-counter to nanosecond timebase discipline core.
// Depends on tsctd_pkg; holds the sequencer and the shared multiply/divide unit.
`timescale 1ns / 1ps

// Usage:
//  - Items enter on req_start while busy is low: req_kind selects init, resync,
//    ticks-to-time, now-ticks-to-time or time-to-ticks.
//  - Every item gives one result, shown for a single cycle with rsp_valid high.
//    The receiver cannot stall; it must take the result in that cycle.
//  - busy stays high from the cycle after acceptance until the result cycle.
//  - All multiplies and divides run through one shift-add multiplier (one
//    multiplier bit per cycle) and one restoring divider (one
//    quotient bit per cycle) under the sequencer.
//  - Work per kind: init and unused kinds go straight to the result; ticks-to-time
//    and time-to-ticks take one multiply and one divide; now-ticks-to-time adds up
//    to four rebase rounds; resync takes up to three divides plus a now conversion.
//  - Registers are written on the csr_ channel (always ready); write them only
//    while the core is idle.
//  - Synchronous reset clears the timebase, loads the reset register values
//    and returns the sequencer to idle.
module tsc_timebase_discipline_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_start,
   output logic        busy,
   input  logic [2:0]  req_kind,
   input  logic [63:0] req_tick_value,
   input  logic [63:0] req_time_value,
   output logic        rsp_valid,
   output logic [63:0] rsp_value,
   output logic        rsp_saturated,
   output logic        rsp_hz_adjusted,
   output logic        rsp_hz_increased,
   output logic        rsp_clock_turned_back,
   output logic        rsp_bounds_widened,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [33:0] csr_wdata
);
   import tsctd_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE, S_MUL, S_DIV, S_DONE,
      CT_START, CT_DIV, CT_FIN,
      CV_START, CV_DIV, CV_FIN,
      CN_START, CN_CHECK, CN_SECS, CN_ADDS, CN_NANO, CN_NADD,
      RS_START, RS_MIN, RS_MINQ, RS_MAXQ, RS_BND, RS_PRED, RS_APPLY
   } state_type;

   state_type   state_ff, state_in, ret_ff, ret_in;
   kind_type    kind_ff, kind_in;
   logic [63:0] tick_ff, tick_in, time_ff, time_in;
   logic [29:0] err_ff, err_in;
   logic [33:0] ihz_ff, ihz_in;
   logic [63:0] btime_ff, btime_in, bticks_ff, bticks_in;
   logic [63:0] stime_ff, stime_in, sticks_ff, sticks_in;
   logic [63:0] freq_ff, freq_in, flo_ff, flo_in, fhi_ff, fhi_in;
   logic [63:0] value_ff, value_in;
   logic        sat_ff, sat_in, adj_ff, adj_in, inc_ff, inc_in;
   logic        back_ff, back_in, wide_ff, wide_in, strobe_ff, strobe_in;
   logic [2:0]  round_ff, round_in;
   logic [63:0] since_ff, since_in, secs_ff, secs_in;
   logic [63:0] smin_ff, smin_in, smax_ff, smax_in;
   logic [63:0] hzmin_ff, hzmin_in, hzmax_ff, hzmax_in, hz_ff, hz_in;
   // Shared multiply/divide unit
   logic [127:0] acc_ff, acc_in, ma_ff, ma_in, nq_ff, nq_in;
   logic [63:0]  mb_ff, mb_in, rem_ff, rem_in, dd_ff, dd_in;
   logic [6:0]   cnt_ff, cnt_in;

   // Unit launch requests from the sequencer
   logic         mul_go, div_go;
   logic [63:0]  mul_a, mul_b, div_d;
   logic [127:0] div_n;
   state_type    go_ret;

   assign busy                  = (state_ff != S_IDLE);
   assign csr_ready             = 1'b1;
   assign rsp_valid             = strobe_ff;
   assign rsp_value             = value_ff;
   assign rsp_saturated         = sat_ff;
   assign rsp_hz_adjusted       = adj_ff;
   assign rsp_hz_increased      = inc_ff;
   assign rsp_clock_turned_back = back_ff;
   assign rsp_bounds_widened    = wide_ff;

   // Sequencer and datapath next values
   always_comb begin
      logic [63:0]  diff, qv, since, upper;
      logic         qsat, below;
      logic [64:0]  r65, s1, s2;
      logic [64:0]  rx;
      logic [127:0] nplus;

      state_in = state_ff;   ret_in = ret_ff;     kind_in = kind_ff;
      tick_in = tick_ff;     time_in = time_ff;   err_in = err_ff;
      ihz_in = ihz_ff;       btime_in = btime_ff; bticks_in = bticks_ff;
      stime_in = stime_ff;   sticks_in = sticks_ff;
      freq_in = freq_ff;     flo_in = flo_ff;     fhi_in = fhi_ff;
      value_in = value_ff;   sat_in = sat_ff;     adj_in = adj_ff;
      inc_in = inc_ff;       back_in = back_ff;   wide_in = wide_ff;
      strobe_in = 1'b0;      round_in = round_ff;
      since_in = since_ff;   secs_in = secs_ff;
      smin_in = smin_ff;     smax_in = smax_ff;
      hzmin_in = hzmin_ff;   hzmax_in = hzmax_ff; hz_in = hz_ff;
      acc_in = acc_ff;       ma_in = ma_ff;       nq_in = nq_ff;
      mb_in = mb_ff;         rem_in = rem_ff;     dd_in = dd_ff;
      cnt_in = cnt_ff;
      mul_go = 1'b0;         div_go = 1'b0;       go_ret = S_IDLE;
      mul_a = '0;            mul_b = '0;          div_n = '0;
      div_d = '0;

      // narrowed quotient of the last divide
      qsat  = (nq_ff[127:64] != 64'd0);
      qv    = qsat ? ALL_ONES : nq_ff[63:0];
      below = (tick_ff < bticks_ff);
      diff  = below ? (bticks_ff - tick_ff) : (tick_ff - bticks_ff);
      since = tick_ff - bticks_ff;
      r65   = {rem_ff, nq_ff[127]};
      s1    = '0;
      s2    = '0;
      rx    = '0;
      upper = '0;
      nplus = '0;

      // register writes
      if (csr_valid) begin
         if (csr_index == CSR_ERROR_NS) err_in = csr_wdata[29:0];
         else ihz_in = csr_wdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               kind_in = kind_type'(req_kind);
               tick_in = req_tick_value;
               time_in = req_time_value;
               value_in = '0;  sat_in = 1'b0;  adj_in = 1'b0;
               inc_in = 1'b0;  back_in = 1'b0; wide_in = 1'b0;
               round_in = '0;
               case (kind_type'(req_kind))
                  KIND_INIT: begin
                     s1 = add_sat(req_time_value, {35'd0, err_ff[29:1]});
                     stime_in = req_time_value;
                     sticks_in = req_tick_value;
                     btime_in = s1[63:0];
                     bticks_in = req_tick_value;
                     freq_in = {30'd0, ihz_ff};
                     flo_in = '0;
                     fhi_in = ALL_ONES;
                     state_in = S_DONE;
                  end
                  KIND_RESYNC:  state_in = RS_START;
                  KIND_TICKS:   state_in = CT_START;
                  KIND_NOW:     state_in = CN_START;
                  KIND_TO_TICK: state_in = CV_START;
                  default:      state_in = S_DONE;
               endcase
            end
         end

         // one multiplier bit per cycle
         S_MUL: begin
            if (mb_ff[0]) acc_in = acc_ff + ma_ff;
            ma_in = {ma_ff[126:0], 1'b0};
            mb_in = {1'b0, mb_ff[63:1]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd63) state_in = ret_ff;
         end

         // one quotient bit per cycle, restoring
         S_DIV: begin
            if (r65 >= {1'b0, dd_ff}) begin
               rx = r65 - {1'b0, dd_ff};
               rem_in = rx[63:0];
               nq_in = {nq_ff[126:0], 1'b1};
            end else begin
               rem_in = r65[63:0];
               nq_in = {nq_ff[126:0], 1'b0};
            end
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd127) state_in = ret_ff;
         end

         S_DONE: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end

         // ticks to time
         CT_START: begin
            mul_go = 1'b1; mul_a = diff; mul_b = NS_PER_S; go_ret = CT_DIV;
         end
         CT_DIV: begin
            div_go = 1'b1; div_n = acc_ff; div_d = freq_ff; go_ret = CT_FIN;
         end
         CT_FIN: begin
            s1 = below ? sub_sat(btime_ff, qv) : add_sat(btime_ff, qv);
            value_in = s1[63:0];
            if (kind_ff == KIND_RESYNC) begin
               state_in = RS_APPLY;
            end else begin
               sat_in = qsat | s1[64];
               state_in = S_DONE;
            end
         end

         // time to ticks
         CV_START: begin
            mul_go = 1'b1;
            mul_a = (time_ff >= btime_ff) ? (time_ff - btime_ff) : (btime_ff - time_ff);
            mul_b = freq_ff;
            go_ret = CV_DIV;
         end
         CV_DIV: begin
            if (acc_ff[127:64] != 64'd0 && time_ff == ALL_ONES) begin
               value_in = ALL_ONES;
               sat_in = 1'b1;
               state_in = S_DONE;
            end else begin
               div_go = 1'b1; div_n = acc_ff; div_d = NS_PER_S; go_ret = CV_FIN;
            end
         end
         CV_FIN: begin
            if (qsat) begin
               sat_in = 1'b1;
               value_in = (time_ff >= btime_ff) ? ALL_ONES : 64'd0;
            end else begin
               s1 = (time_ff >= btime_ff) ? add_sat(nq_ff[63:0], bticks_ff)
                                          : sub_sat(bticks_ff, nq_ff[63:0]);
               value_in = s1[63:0];
               sat_in = s1[64];
            end
            state_in = S_DONE;
         end

         // now conversion: rebase by whole seconds first
         CN_START: begin
            round_in = '0;
            if (freq_ff == 64'd0 || below) state_in = CT_START;
            else state_in = CN_CHECK;
         end
         CN_CHECK: begin
            if (round_ff == 3'd4 || since <= SEC_LIMIT) begin
               state_in = CT_START;
            end else begin
               since_in = since;
               div_go = 1'b1; div_n = {64'd0, since}; div_d = freq_ff; go_ret = CN_SECS;
            end
         end
         CN_SECS: begin
            secs_in = nq_ff[63:0];
            bticks_in = bticks_ff + (since_ff - rem_ff);
            if (nq_ff[63:0] > SEC_LIMIT) begin
               btime_in = ALL_ONES;
               round_in = round_ff + 3'd1;
               state_in = CN_CHECK;
            end else begin
               mul_go = 1'b1; mul_a = nq_ff[63:0]; mul_b = NS_PER_S; go_ret = CN_ADDS;
            end
         end
         CN_ADDS: begin
            s1 = add_sat(btime_ff, acc_ff[63:0]);
            btime_in = s1[63:0];
            if (secs_ff == 64'd0) begin
               div_go = 1'b1; div_n = {64'd0, freq_ff}; div_d = NS_PER_S; go_ret = CN_NANO;
            end else begin
               round_in = round_ff + 3'd1;
               state_in = CN_CHECK;
            end
         end
         CN_NANO: begin
            if (nq_ff[63:0] == 64'd0) begin
               state_in = CT_START;
            end else begin
               div_go = 1'b1; div_n = {64'd0, since_ff}; div_d = nq_ff[63:0];
               go_ret = CN_NADD;
            end
         end
         CN_NADD: begin
            s1 = add_sat(btime_ff, nq_ff[63:0]);
            btime_in = s1[63:0];
            bticks_in = bticks_ff + (since_ff - rem_ff);
            round_in = round_ff + 3'd1;
            state_in = CN_CHECK;
         end

         // resync: window edges, rate bounds, prediction check and rate update
         RS_START: begin
            s1 = add_sat(stime_ff, {34'd0, err_ff});
            s2 = add_sat(time_ff, {34'd0, err_ff});
            smin_in = (time_ff < s1[63:0]) ? 64'd0 : (time_ff - s1[63:0]);
            smax_in = (s2[63:0] < stime_ff) ? 64'd0 : (s2[63:0] - stime_ff);
            mul_go = 1'b1; mul_a = tick_ff - sticks_ff; mul_b = NS_PER_S; go_ret = RS_MIN;
         end
         RS_MIN: begin
            div_go = 1'b1; div_n = acc_ff; div_d = smax_ff; go_ret = RS_MINQ;
         end
         RS_MINQ: begin
            hzmin_in = qv;
            if (smin_ff != 64'd0) begin
               nplus = acc_ff + {64'd0, smin_ff - 64'd1};
               div_go = 1'b1; div_n = nplus; div_d = smin_ff; go_ret = RS_MAXQ;
            end else begin
               hzmax_in = ALL_ONES;
               state_in = RS_BND;
            end
         end
         RS_MAXQ: begin
            hzmax_in = qv;
            state_in = RS_BND;
         end
         RS_BND: begin
            wide_in = (hzmin_ff < flo_ff) || (hzmax_ff > fhi_ff);
            flo_in = hzmin_ff;
            fhi_in = hzmax_ff;
            if (freq_ff >= hzmin_ff && freq_ff <= hzmax_ff) begin
               state_in = S_DONE;
            end else begin
               div_go = 1'b1; div_n = acc_ff; div_d = freq_ff; go_ret = RS_PRED;
            end
         end
         RS_PRED: begin
            if (qv >= smin_ff && qv <= smax_ff) begin
               state_in = S_DONE;
            end else begin
               hz_in = (freq_ff < hzmin_ff) ? hzmin_ff : hzmax_ff;
               state_in = CN_START;
            end
         end
         RS_APPLY: begin
            s1 = add_sat(time_ff, {34'd0, err_ff});
            upper = s1[63:0];
            if (value_ff < time_ff) begin
               btime_in = time_ff;
            end else if (value_ff > upper) begin
               btime_in = upper;
               back_in = 1'b1;
            end else begin
               btime_in = value_ff;
            end
            bticks_in = tick_ff;
            inc_in = (hz_ff > freq_ff);
            freq_in = hz_ff;
            adj_in = 1'b1;
            value_in = '0;
            state_in = S_DONE;
         end
         default: state_in = S_IDLE;
      endcase

      // launch the shared unit
      if (mul_go) begin
         ma_in = {64'd0, mul_a};
         mb_in = mul_b;
         acc_in = '0;
         cnt_in = '0;
         ret_in = go_ret;
         state_in = S_MUL;
      end
      if (div_go) begin
         if (div_d == 64'd0) begin
            nq_in = {2{ALL_ONES}};
            state_in = go_ret;
         end else begin
            nq_in = div_n;
            rem_in = '0;
            dd_in = div_d;
            cnt_in = '0;
            ret_in = go_ret;
            state_in = S_DIV;
         end
      end
   end

   // State and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         ret_ff    <= S_IDLE;
         strobe_ff <= 1'b0;
         err_ff    <= ERROR_NS_RESET;
         ihz_ff    <= INITIAL_HZ_RESET;
         btime_ff  <= '0;
         bticks_ff <= '0;
         stime_ff  <= '0;
         sticks_ff <= '0;
         freq_ff   <= {30'd0, INITIAL_HZ_RESET};
         flo_ff    <= '0;
         fhi_ff    <= ALL_ONES;
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         strobe_ff <= strobe_in;
         err_ff    <= err_in;
         ihz_ff    <= ihz_in;
         btime_ff  <= btime_in;
         bticks_ff <= bticks_in;
         stime_ff  <= stime_in;
         sticks_ff <= sticks_in;
         freq_ff   <= freq_in;
         flo_ff    <= flo_in;
         fhi_ff    <= fhi_in;
      end
      kind_ff   <= kind_in;
      tick_ff   <= tick_in;
      time_ff   <= time_in;
      value_ff  <= value_in;
      sat_ff    <= sat_in;
      adj_ff    <= adj_in;
      inc_ff    <= inc_in;
      back_ff   <= back_in;
      wide_ff   <= wide_in;
      round_ff  <= round_in;
      since_ff  <= since_in;
      secs_ff   <= secs_in;
      smin_ff   <= smin_in;
      smax_ff   <= smax_in;
      hzmin_ff  <= hzmin_in;
      hzmax_ff  <= hzmax_in;
      hz_ff     <= hz_in;
      acc_ff    <= acc_in;
      ma_ff     <= ma_in;
      nq_ff     <= nq_in;
      mb_ff     <= mb_in;
      rem_ff    <= rem_in;
      dd_ff     <= dd_in;
      cnt_ff    <= cnt_in;
   end

endmodule

// ===== dv/tsc_timebase_discipline_core_test.sv =====
// Self-checking testbench for tsc_timebase_discipline_core.
// Drives init, resync, conversion and unused-kind items and checks each result against a
// built-in model of the timebase; depends on tsctd_pkg.
`timescale 1ns / 1ps

module tsc_timebase_discipline_core_test;
   import tsctd_pkg::*;

   typedef struct packed {
      logic [63:0] value;
      logic        saturated;
      logic        hz_adjusted;
      logic        hz_increased;
      logic        turned_back;
      logic        widened;
   } timebase_result_type;

   // Timebase model plus the queue of results still owed by the core
   class scoreboard_type;
      logic [63:0] err_ns, init_hz;
      logic [63:0] b_time, b_ticks, s_time, s_ticks, hz, hz_lo, hz_hi;
      timebase_result_type owed[$];
      int failures;

      function new();
         err_ns = 64'(ERROR_NS_RESET);
         init_hz = 64'(INITIAL_HZ_RESET);
         b_time = 0; b_ticks = 0; s_time = 0; s_ticks = 0;
         hz = init_hz; hz_lo = 0; hz_hi = ALL_ONES;
         failures = 0;
      endfunction

      function void set_register(logic idx, logic [33:0] data);
         if (idx == CSR_ERROR_NS) err_ns = 64'(data[29:0]);
         else init_hz = 64'(data);
      endfunction

      function logic [63:0] sadd(logic [63:0] a, logic [63:0] b, inout bit sat);
         logic [64:0] s;
         s = {1'b0, a} + {1'b0, b};
         if (s[64]) begin
            sat = 1;
            return ALL_ONES;
         end
         return s[63:0];
      endfunction

      function logic [63:0] ssub(logic [63:0] a, logic [63:0] b, inout bit sat);
         if (b > a) begin
            sat = 1;
            return 0;
         end
         return a - b;
      endfunction

      function logic [127:0] wmul(logic [63:0] a, logic [63:0] b);
         return {64'd0, a} * {64'd0, b};
      endfunction

      function logic [127:0] wdiv(logic [127:0] n, logic [63:0] d);
         if (d == 0) return {128{1'b1}};
         return n / {64'd0, d};
      endfunction

      function logic [63:0] clip(logic [127:0] q, inout bit sat);
         if (q[127:64] != 0) begin
            sat = 1;
            return ALL_ONES;
         end
         return q[63:0];
      endfunction

      function logic [63:0] span_ns(logic [63:0] t, inout bit sat);
         return clip(wdiv(wmul(t, NS_PER_S), hz), sat);
      endfunction

      // Span first, so its saturation is kept by the add or subtract
      function logic [63:0] ticks_time(logic [63:0] t, inout bit sat);
         logic [63:0] d;
         if (t < b_ticks) begin
            d = span_ns(b_ticks - t, sat);
            return ssub(b_time, d, sat);
         end
         d = span_ns(t - b_ticks, sat);
         return sadd(b_time, d, sat);
      endfunction

      // Advances the baseline by whole seconds before converting
      function logic [63:0] now_time(logic [63:0] t, inout bit sat);
         bit dummy;
         logic [63:0] since, secs, rest, nano;
         dummy = 0;
         if (hz == 0 || t < b_ticks) return ticks_time(t, sat);
         for (int r = 0; r < 4; r++) begin
            since = t - b_ticks;
            if (since <= SEC_LIMIT) break;
            secs = since / hz;
            rest = since % hz;
            b_time = sadd(b_time, secs > SEC_LIMIT ? ALL_ONES : secs * NS_PER_S, dummy);
            b_ticks += since - rest;
            if (secs == 0) begin
               nano = hz / NS_PER_S;
               if (nano == 0) break;
               b_time = sadd(b_time, since / nano, dummy);
               b_ticks += since - since % nano;
            end
         end
         return ticks_time(t, sat);
      endfunction

      function logic [63:0] time_ticks(logic [63:0] kt, inout bit sat);
         bit later;
         logic [63:0] gap;
         logic [127:0] p, q;
         later = kt >= b_time;
         gap = later ? kt - b_time : b_time - kt;
         p = wmul(gap, hz);
         if (p[127:64] != 0 && kt == ALL_ONES) begin
            sat = 1;
            return ALL_ONES;
         end
         q = wdiv(p, NS_PER_S);
         if (q[127:64] != 0) begin
            sat = 1;
            return later ? ALL_ONES : 0;
         end
         return later ? sadd(q[63:0], b_ticks, sat) : ssub(b_ticks, q[63:0], sat);
      endfunction

      function logic [63:0] rate(logic [63:0] t, logic [63:0] span, bit up);
         bit dummy;
         logic [127:0] w;
         dummy = 0;
         if (span == 0) return ALL_ONES;
         w = wmul(t, NS_PER_S);
         if (up) w = w + {64'd0, span - 64'd1};
         return clip(wdiv(w, span), dummy);
      endfunction

      function void resync(logic [63:0] t, logic [63:0] kt, inout timebase_result_type r);
         bit dummy, fl;
         logic [63:0] passed, lo_edge, smin, hi_edge, smax, hmin, hmax, f, pred, cnow;
         dummy = 0;
         fl = 0;
         passed = t - s_ticks;
         lo_edge = sadd(s_time, err_ns, dummy);
         smin = kt < lo_edge ? 0 : kt - lo_edge;
         hi_edge = sadd(kt, err_ns, dummy);
         smax = hi_edge < s_time ? 0 : hi_edge - s_time;
         hmin = rate(passed, smax, 0);
         hmax = smin != 0 ? rate(passed, smin, 1) : ALL_ONES;
         f = hz;
         r.widened = hmin < hz_lo || hmax > hz_hi;
         hz_lo = hmin;
         hz_hi = hmax;
         if (!(f >= hmin && f <= hmax)) begin
            pred = span_ns(passed, dummy);
            if (!(pred >= smin && pred <= smax)) begin
               f = f < hmin ? hmin : hmax;
               cnow = now_time(t, dummy);
               if (cnow < kt) cnow = kt;
               else if (cnow > sadd(kt, err_ns, dummy)) begin
                  cnow = sadd(kt, err_ns, dummy);
                  r.turned_back = 1;
               end
               b_time = cnow;
               b_ticks = t;
               r.hz_increased = f > hz;
               hz = f;
               r.hz_adjusted = 1;
            end
         end
      endfunction

      // Accepted request: update the model and queue the owed result
      function void note_request(logic [2:0] kind, logic [63:0] t, logic [63:0] kt);
         timebase_result_type r;
         bit sat, dummy;
         r = '0;
         sat = 0;
         dummy = 0;
         case (kind)
            KIND_INIT: begin
               s_time = kt;
               s_ticks = t;
               b_time = sadd(kt, err_ns / 2, dummy);
               b_ticks = t;
               hz = init_hz;
               hz_lo = 0;
               hz_hi = ALL_ONES;
            end
            KIND_RESYNC:  resync(t, kt, r);
            KIND_TICKS:   r.value = ticks_time(t, sat);
            KIND_NOW:     r.value = now_time(t, sat);
            KIND_TO_TICK: r.value = time_ticks(kt, sat);
            default: ;
         endcase
         r.saturated = sat;
         owed.push_back(r);
      endfunction

      function void check_result(timebase_result_type got);
         timebase_result_type e;
         if (owed.size() == 0) begin
            $error("result with nothing owed: value %h", got.value);
            failures++;
            return;
         end
         e = owed.pop_front();
         if (got.value !== e.value) begin
            $error("value: expected %h, actual %h", e.value, got.value);
            failures++;
         end
         if (got.saturated !== e.saturated) begin
            $error("saturated: expected %b, actual %b", e.saturated, got.saturated);
            failures++;
         end
         if (got.hz_adjusted !== e.hz_adjusted) begin
            $error("hz_adjusted: expected %b, actual %b", e.hz_adjusted, got.hz_adjusted);
            failures++;
         end
         if (got.hz_increased !== e.hz_increased) begin
            $error("hz_increased: expected %b, actual %b", e.hz_increased, got.hz_increased);
            failures++;
         end
         if (got.turned_back !== e.turned_back) begin
            $error("clock_turned_back: expected %b, actual %b", e.turned_back,
                   got.turned_back);
            failures++;
         end
         if (got.widened !== e.widened) begin
            $error("bounds_widened: expected %b, actual %b", e.widened, got.widened);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_start = 0;
   logic        busy;
   logic [2:0]  req_kind = 0;
   logic [63:0] req_tick_value = 0;
   logic [63:0] req_time_value = 0;
   logic        rsp_valid, rsp_saturated, rsp_hz_adjusted, rsp_hz_increased;
   logic        rsp_clock_turned_back, rsp_bounds_widened;
   logic [63:0] rsp_value;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic        csr_index = 0;
   logic [33:0] csr_wdata = 0;

   tsc_timebase_discipline_core dut (.*);

   always #10 clock = ~clock;

   scoreboard_type sb = new();
   int idle_pct = 0;
   int stall_cycles = 0;
   logic [63:0] run_ticks, run_time;

   // Result monitor and watchdog on cycles without a transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_result({rsp_value, rsp_saturated, rsp_hz_adjusted, rsp_hz_increased,
                             rsp_clock_turned_back, rsp_bounds_widened});
         if (rsp_valid || (req_start && !busy) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= 20000) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   task automatic send(logic [2:0] kind, logic [63:0] t, logic [63:0] kt);
      while (busy || $urandom_range(99) < idle_pct) @(negedge clock);
      req_start = 1;
      req_kind = kind;
      req_tick_value = t;
      req_time_value = kt;
      sb.note_request(kind, t, kt);
      @(negedge clock);
      req_start = 0;
   endtask

   task automatic csr_write(logic idx, logic [33:0] data);
      csr_valid = 1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_valid = 0;
   endtask

   task automatic drain();
      while (sb.owed.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom} >> $urandom_range(63);
   endfunction

   // Mostly plausible init/resync/convert sequences, some noise
   task automatic random_items(int count);
      logic [63:0] dt, jit;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 25) begin
            send(3'($urandom_range(7)), rand64(), rand64());
         end else if ($urandom_range(99) < 8) begin
            run_ticks = rand64();
            run_time = rand64();
            send(KIND_INIT, run_ticks, run_time);
         end else begin
            dt = $urandom_range(3) == 0 ? rand64() : 64'($urandom_range(2000000000));
            jit = 64'($urandom_range(4000000));
            run_ticks += dt;
            run_time += dt + jit - 64'd2000000 + ($urandom_range(3) == 0 ? dt / 64 : 0);
            case ($urandom_range(4))
               0, 1: send(KIND_RESYNC, run_ticks, run_time);
               2:    send(KIND_TICKS, run_ticks, run_time);
               3:    send(KIND_NOW, run_ticks, run_time);
               default: send(KIND_TO_TICK, run_ticks,
                             run_time + 64'($urandom_range(100000)) - 64'd50000);
            endcase
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset = 0;

      // Directed: field extremes, every kind, special cases
      send(KIND_TICKS, 0, 0);
      send(KIND_TICKS, ALL_ONES, 0);
      send(KIND_TO_TICK, 0, ALL_ONES);
      send(KIND_NOW, ALL_ONES, 0);
      send(3'd5, ALL_ONES, ALL_ONES);
      send(3'd7, 0, 0);
      send(KIND_INIT, 64'd1000, 64'd5000000);
      send(KIND_TICKS, 64'd0, 0);
      send(KIND_TO_TICK, 0, 64'd0);
      send(KIND_TO_TICK, 0, ALL_ONES);
      send(KIND_RESYNC, 64'd1000, 64'd5000000);
      send(KIND_RESYNC, 64'd3000001000, 64'd1005000000);
      send(KIND_RESYNC, 64'd4000001000, 64'd1105000000);
      send(KIND_NOW, ALL_ONES, 0);
      send(KIND_NOW, 64'h0000_00FF_0000_0000, 0);
      send(KIND_TICKS, 0, 0);
      send(KIND_INIT, ALL_ONES, ALL_ONES);
      send(KIND_RESYNC, 0, 0);
      send(KIND_TO_TICK, 0, 0);
      send(KIND_TO_TICK, 0, ALL_ONES - 1);
      send(3'd6, 0, 0);
      drain();

      // Smallest window and frequency, sender idles
      csr_write(CSR_ERROR_NS, 34'd0);
      csr_write(CSR_INITIAL_HZ, 34'd1);
      idle_pct = 30;
      run_ticks = 0; run_time = 0;
      send(KIND_INIT, 0, 0);
      random_items(600);
      drain();

      // Largest window and frequency, sender idles more often
      csr_write(CSR_ERROR_NS, 34'd1000000000);
      csr_write(CSR_INITIAL_HZ, 34'd10000000000);
      idle_pct = 59;
      send(KIND_INIT, run_ticks, run_time);
      random_items(600);
      drain();

      // Random settings, back to back
      csr_write(CSR_ERROR_NS, 34'($urandom_range(1000000000)));
      csr_write(CSR_INITIAL_HZ, 34'($urandom_range(1, 2000000000)) * 34'($urandom_range(1, 4)));
      idle_pct = 0;
      send(KIND_INIT, run_ticks, run_time);
      random_items(600);
      drain();
      repeat (50) @(negedge clock);

      if (sb.failures == 0 && sb.owed.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
